/* rtl/core/skrf_pkg.sv */
package skrf_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned RawW    = 16;
  localparam int unsigned GainW   = 17;
  localparam int unsigned CfgIdxW = 3;

  // Shared multiplier: innovation magnitude (35 bits) times a 32-bit operand
  localparam int unsigned MulAW = 35;
  localparam int unsigned MulBW = 32;
  localparam int unsigned MulPW = MulAW + MulBW;

  // Gain divider: numerator (p << 16) + den / 2, 33-bit denominator, 17 quotient bits
  localparam int unsigned DenW     = DataW + 1;
  localparam int unsigned DivSteps = GainW;
  localparam int unsigned NumW     = DataW + DivSteps;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  localparam logic [GainW-1:0] GainOne = GainW'(65536);

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgProcessNoise     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMeasurementNoise = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgAccelScale       = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgAccelBias        = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgImuWeight        = 3'd4;

  // Reset values
  localparam logic [DataW-1:0] RstProcessNoise     = 32'd8192;
  localparam logic [DataW-1:0] RstMeasurementNoise = 32'd52429;
  localparam logic [DataW-1:0] RstAccelScale       = 32'd15390882;
  localparam logic [DataW-1:0] RstAccelBias        = 32'hFFF7_B830;
  localparam logic [DataW-1:0] RstImuWeight        = 32'd4294967;
  localparam logic [DataW-1:0] RstCovariance       = 32'd65536;

endpackage

/* rtl/core/skrf_mul.sv */
module skrf_mul import skrf_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [MulAW-1:0] a_i,
  input  logic [MulBW-1:0] b_i,
  output logic [MulPW-1:0] prod_o
);

  logic [MulPW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= MulPW'(a_i) * MulPW'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

/* rtl/core/skrf_div.sv */
module skrf_div import skrf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumW-1:0]    num_i,
  input  logic [DenW-1:0]    den_i,
  output logic               done_o,
  output logic [GainW-1:0]   quot_o
);

  // Restoring division, one quotient bit per cycle. Top 32 numerator bits
  // are already below the divisor, so only the low bits are shifted in.
  logic [DenW-1:0]     rem_q, rem_d;
  logic [DivSteps-1:0] low_q;
  logic [GainW-1:0]    quot_q;
  logic [DivCntW-1:0]  cnt_q;
  logic                busy_q, done_q;
  logic [DenW:0]       trial;
  logic                ge;

  always_comb begin
    trial = {rem_q, low_q[DivSteps-1]};
    ge    = (trial >= {1'b0, den_i});
    rem_d = ge ? DenW'(trial - {1'b0, den_i}) : trial[DenW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DivCntW'(DivSteps);
    end else if (busy_q) begin
      cnt_q <= cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i[NumW-1:DivSteps]};
      low_q  <= num_i[DivSteps-1:0];
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      low_q  <= {low_q[DivSteps-2:0], 1'b0};
      quot_q <= {quot_q[GainW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* rtl/core/scalar_kalman_range_fusion.sv */
// Scalar Kalman range fusion. Each input transaction (range distance, raw accelerometer X)
// is calibrated, weighted, added to the distance and fed to a one-dimensional Kalman
// filter; exactly one result transaction (saturated estimate, gain in Q1.16) comes back.
// The block takes no new input until it is through with the last one: in_stall_o is high
// from acceptance until the sequencer has loaded the result and returned to idle. A single
// 35x32 multiplier is reused four times (calibration, weighting, correction, covariance)
// and the gain comes from a 17-step restoring divider that runs alongside the weighting
// multiply; the sequencer waits for it before the correction. The finished result sits in
// an output register, so the next item is accepted while it still waits to be taken.
// Configuration writes are always ready and must only be issued while the block is idle.
module scalar_kalman_range_fusion import skrf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [DataW-1:0]         cfg_data_i,
  // input items
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DataW-1:0]  range_distance_i,
  input  logic signed [RawW-1:0]   accel_x_raw_i,
  // results
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DataW-1:0]  fused_range_o,
  output logic [GainW-1:0]         kalman_gain_o
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0_0000_0000_0001,
    S_PREP  = 13'b0_0000_0000_0010,
    S_CAL   = 13'b0_0000_0000_0100,
    S_CALR  = 13'b0_0000_0000_1000,
    S_WTD   = 13'b0_0000_0001_0000,
    S_WTDR  = 13'b0_0000_0010_0000,
    S_MEAS  = 13'b0_0000_0100_0000,
    S_INNOV = 13'b0_0000_1000_0000,
    S_DIVW  = 13'b0_0001_0000_0000,
    S_CORR  = 13'b0_0010_0000_0000,
    S_CORRR = 13'b0_0100_0000_0000,
    S_EST   = 13'b0_1000_0000_0000,
    S_COV   = 13'b1_0000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [DataW-1:0] pn_q, mn_q, scale_q, bias_q, weight_q;
  // filter state
  logic signed [DataW-1:0] est_q;
  logic [DataW-1:0]        cov_q;

  // per-item working registers
  logic signed [DataW-1:0] dist_q;
  logic signed [RawW-1:0]  raw_q;
  logic                    neg_q;        // sign of calibrated / weighted acceleration
  logic [DataW-1:0]        diff_mag_q;
  logic [DataW-1:0]        p_q;          // predicted covariance, saturated
  logic [DenW-1:0]         den_q;
  logic [DataW-1:0]        cal_mag_q;
  logic [DataW-1:0]        wtd_mag_q;
  logic signed [DataW+1:0] meas_q;       // 34 bits, exact
  logic                    innov_neg_q;
  logic [MulAW-1:0]        innov_mag_q;
  logic [GainW-1:0]        gain_q;
  logic [MulAW-1:0]        corr_mag_q;
  logic signed [DataW-1:0] est_new_q;

  logic                    out_valid_q;
  logic signed [DataW-1:0] out_dist_q;
  logic [GainW-1:0]        out_gain_q;

  logic in_acc, out_load, out_blocked;

  // shared multiplier and divider hookup
  logic             mul_en;
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] mul_prod;
  logic [MulPW-1:0] rnd_const, rnd_sum;
  logic             div_start, div_done;
  logic [NumW-1:0]  div_num;
  logic [GainW-1:0] div_quot;

  // combinational datapath pieces
  logic signed [DataW:0]   diff_s;
  logic [DataW:0]          diff_abs;
  logic [DataW:0]          p_sum;
  logic signed [DataW+1:0] dist_ext, wtd_ext;
  logic signed [MulAW-1:0] innov_s, innov_abs;
  logic signed [DataW+4:0] nx_s;
  logic signed [DataW+4:0] corr_ext;
  logic [GainW-1:0]        one_minus_gain;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_blocked = out_valid_q && out_stall_i;
  assign out_load    = (state_q == S_COV) && !out_blocked;

  // ---------------------------------------------------------------------------
  // Configuration writes; unknown indexes are dropped
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pn_q     <= RstProcessNoise;
      mn_q     <= RstMeasurementNoise;
      scale_q  <= RstAccelScale;
      bias_q   <= RstAccelBias;
      weight_q <= RstImuWeight;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgProcessNoise:     pn_q     <= cfg_data_i;
        CfgMeasurementNoise: mn_q     <= cfg_data_i;
        CfgAccelScale:       scale_q  <= cfg_data_i;
        CfgAccelBias:        bias_q   <= cfg_data_i;
        CfgImuWeight:        weight_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_PREP;
      S_PREP:  state_d = S_CAL;
      S_CAL:   state_d = S_CALR;
      S_CALR:  state_d = S_WTD;
      S_WTD:   state_d = S_WTDR;
      S_WTDR:  state_d = S_MEAS;
      S_MEAS:  state_d = S_INNOV;
      S_INNOV: state_d = S_DIVW;
      S_DIVW:  if (div_done) state_d = S_CORR;
      S_CORR:  state_d = S_CORRR;
      S_CORRR: state_d = S_EST;
      S_EST:   state_d = S_COV;
      S_COV:   if (!out_blocked) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier operand select and rounding adder
  // ---------------------------------------------------------------------------
  assign one_minus_gain = GainOne - gain_q;

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      S_CAL: begin
        mul_en = 1'b1;
        mul_a  = MulAW'(diff_mag_q);
        mul_b  = scale_q;
      end
      S_WTD: begin
        mul_en = 1'b1;
        mul_a  = MulAW'(cal_mag_q);
        mul_b  = weight_q;
      end
      S_CORR: begin
        mul_en = 1'b1;
        mul_a  = innov_mag_q;
        mul_b  = MulBW'(gain_q);
      end
      S_EST: begin
        mul_en = 1'b1;
        mul_a  = MulAW'(one_minus_gain);
        mul_b  = p_q;
      end
      default: ;
    endcase
  end

  skrf_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_prod)
  );

  // half an LSB: 2^31 for the Q0.32 scalings, 2^15 for the Q1.16 ones
  assign rnd_const = ((state_q == S_CALR) || (state_q == S_WTDR)) ? (MulPW'(1) << 31)
                                                                  : (MulPW'(1) << 15);
  assign rnd_sum   = mul_prod + rnd_const;

  // ---------------------------------------------------------------------------
  // Gain divider
  // ---------------------------------------------------------------------------
  assign div_start = (state_q == S_CALR);
  assign div_num   = {1'b0, p_q, 16'b0} + NumW'(den_q[DenW-1:1]);

  skrf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  always_comb begin
    diff_s   = $signed({raw_q[RawW-1], raw_q, 16'b0}) - $signed({bias_q[DataW-1], bias_q});
    diff_abs = diff_s[DataW] ? -diff_s : diff_s;
    p_sum    = {1'b0, cov_q} + {1'b0, pn_q};
    dist_ext = (DataW+2)'(dist_q);
    wtd_ext  = $signed({2'b00, wtd_mag_q});
    innov_s  = MulAW'(meas_q) - MulAW'(est_q);
    innov_abs = innov_s[MulAW-1] ? -innov_s : innov_s;
    corr_ext = $signed({2'b00, corr_mag_q});
    nx_s     = innov_neg_q ? (DataW+5)'(est_q) - corr_ext : (DataW+5)'(est_q) + corr_ext;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dist_q <= range_distance_i;
      raw_q  <= accel_x_raw_i;
    end
    unique case (state_q)
      S_PREP: begin
        neg_q      <= diff_s[DataW];
        diff_mag_q <= diff_abs[DataW-1:0];
        p_q        <= p_sum[DataW] ? '1 : p_sum[DataW-1:0];
      end
      S_CAL:   den_q      <= {1'b0, p_q} + {1'b0, mn_q};
      S_CALR:  cal_mag_q  <= rnd_sum[63:32];
      S_WTDR:  wtd_mag_q  <= rnd_sum[63:32];
      S_MEAS:  meas_q     <= neg_q ? dist_ext - wtd_ext : dist_ext + wtd_ext;
      S_INNOV: begin
        innov_neg_q <= innov_s[MulAW-1];
        innov_mag_q <= innov_abs;
      end
      S_DIVW: begin
        if (den_q == '0) begin
          gain_q <= '0;
        end else begin
          gain_q <= (div_quot > GainOne) ? GainOne : div_quot;
        end
      end
      S_CORRR: corr_mag_q <= rnd_sum[MulAW+15:16];
      S_EST: begin
        // clamp to the signed Q16.16 limits
        if (nx_s > (DataW+5)'(32'sh7FFF_FFFF)) begin
          est_new_q <= 32'sh7FFF_FFFF;
        end else if (nx_s < (DataW+5)'(32'sh8000_0000)) begin
          est_new_q <= 32'sh8000_0000;
        end else begin
          est_new_q <= nx_s[DataW-1:0];
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_dist_q <= est_new_q;
      out_gain_q <= gain_q;
    end
  end

  // filter state and result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q       <= '0;
      cov_q       <= RstCovariance;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        est_q       <= est_new_q;
        cov_q       <= rnd_sum[47:16];
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign fused_range_o = out_dist_q;
  assign kalman_gain_o = out_gain_q;

`ifndef ASSERT_OFF
  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kalman_gain_o <= GainOne))
    else $error("gain above one");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_PREP) && in_stall_o)
    else $error("accepted transaction did not start the sequencer");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o && (state_q == S_IDLE))
    else $error("finished result not presented");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_COV) && out_blocked) |=> (state_q == S_COV))
    else $error("sequencer left final step while output was stalled");
`endif

endmodule

/* dv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import skrf_pkg::*;

  // Run control
  localparam int unsigned HoldCycles   = 300;        // long output hold-off
  localparam int unsigned SettleCycles = 40;         // settle margin after the last result
  localparam int unsigned RandomItems  = 1000;
  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned ReportLimit  = 10;

  // Top of the index space; everything above CfgImuWeight is unmapped
  localparam logic [CfgIdxW-1:0] CfgIdxLast = '1;

  typedef struct packed {
    logic signed [DataW-1:0] distance;
    logic [GainW-1:0]        gain;
  } fusion_result_t;

  // Tracks the filter state, predicts each fused result and checks it in order.
  class fusion_scoreboard;
    logic [DataW-1:0]        process_noise;
    logic [DataW-1:0]        measurement_noise;
    logic [DataW-1:0]        accel_scale;
    logic signed [DataW-1:0] accel_bias;
    logic [DataW-1:0]        imu_weight;
    logic signed [DataW-1:0] estimate;
    logic [DataW-1:0]        covariance;
    fusion_result_t          pending_fusions[$];
    int unsigned             mismatches;
    int unsigned             checked;

    function new();
      process_noise     = RstProcessNoise;
      measurement_noise = RstMeasurementNoise;
      accel_scale       = RstAccelScale;
      accel_bias        = RstAccelBias;
      imu_weight        = RstImuWeight;
      estimate          = '0;
      covariance        = RstCovariance;
      mismatches        = 0;
      checked           = 0;
    endfunction

    function void write_register(logic [CfgIdxW-1:0] index, logic [DataW-1:0] data);
      case (index)
        CfgProcessNoise:     process_noise = data;
        CfgMeasurementNoise: measurement_noise = data;
        CfgAccelScale:       accel_scale = data;
        CfgAccelBias:        accel_bias = data;
        CfgImuWeight:        imu_weight = data;
        default: ;           // unmapped index, dropped
      endcase
    endfunction

    // a * b / 2^sh, nearest, ties away from zero; 128-bit so nothing wraps
    function longint round_half_away(longint a, longint unsigned b, int unsigned sh);
      bit         neg;
      bit [127:0] mag;
      bit [127:0] prod;
      neg  = (a < 0);
      mag  = neg ? 128'(-a) : 128'(a);
      prod = (mag * 128'(b) + (128'd1 << (sh - 1))) >> sh;
      return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function void note_ranging_event(logic signed [DataW-1:0] range_in,
                                     logic signed [RawW-1:0] raw);
      longint          diff;
      longint          calibrated;
      longint          weighted;
      longint          measurement;
      longint          innovation;
      longint          correction;
      longint          next_estimate;
      longint unsigned prior;
      longint unsigned denom;
      longint unsigned gain;
      fusion_result_t  res;

      diff        = longint'(raw) * 64'sd65536 - longint'(accel_bias);
      calibrated  = round_half_away(diff, 64'(accel_scale), 32);
      weighted    = round_half_away(calibrated, 64'(imu_weight), 32);
      measurement = longint'(range_in) + weighted;

      // predict: covariance grows by process noise, clipped to 32 bits
      prior = 64'(covariance) + 64'(process_noise);
      if (prior > 64'hFFFF_FFFF) prior = 64'hFFFF_FFFF;

      // gain in Q1.16, zero when the denominator vanishes
      denom = prior + 64'(measurement_noise);
      gain  = 0;
      if (denom != 0) gain = ((prior << 16) + (denom >> 1)) / denom;
      if (gain > 64'd65536) gain = 64'd65536;

      innovation    = measurement - longint'(estimate);
      correction    = round_half_away(innovation, gain, 16);
      next_estimate = longint'(estimate) + correction;
      if (next_estimate > 64'sd2147483647) next_estimate = 64'sd2147483647;
      if (next_estimate < -64'sd2147483648) next_estimate = -64'sd2147483648;
      estimate   = next_estimate[DataW-1:0];
      covariance = DataW'(((64'd65536 - gain) * prior + 64'd32768) >> 16);

      res.distance = estimate;
      res.gain     = gain[GainW-1:0];
      pending_fusions.push_back(res);
    endfunction

    function void check_fused_output(logic signed [DataW-1:0] fused,
                                     logic [GainW-1:0] gain);
      fusion_result_t want;
      if (pending_fusions.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected result: fused_range %0d kalman_gain %0d", fused, gain);
        return;
      end
      want = pending_fusions.pop_front();
      checked++;
      if (fused !== want.distance || gain !== want.gain) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("result %0d: fused_range exp %0d got %0d, kalman_gain exp %0d got %0d",
                   checked, $signed(want.distance), fused, want.gain, gain);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Block connections; every input starts from a known value
  // ---------------------------------------------------------------------------
  logic                    clk_i            = 1'b0;
  logic                    rst_ni           = 1'b0;
  logic                    cfg_valid_i      = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxW-1:0]      cfg_index_i      = '0;
  logic [DataW-1:0]        cfg_data_i       = '0;
  logic                    in_valid_i       = 1'b0;
  logic                    in_stall_o;
  logic signed [DataW-1:0] range_distance_i = '0;
  logic signed [RawW-1:0]  accel_x_raw_i    = '0;
  logic                    out_valid_o;
  logic                    out_stall_i      = 1'b0;
  logic signed [DataW-1:0] fused_range_o;
  logic [GainW-1:0]        kalman_gain_o;

  scalar_kalman_range_fusion DUT (.*);

  fusion_scoreboard fusion_sb;

  // Traffic shaping, set per phase by the stimulus
  bit          feed_gaps_on    = 1'b1;
  bit          drain_stalls_on = 1'b1;
  int unsigned hold_requested  = 0;
  int unsigned hold_served     = 0;
  int unsigned stall_left      = 0;

  // Run statistics
  int unsigned cycle_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned directed_sent = 0;
  int unsigned random_sent   = 0;
  int unsigned reg_writes    = 0;
  int unsigned settings_used = 0;

  always #2 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, fusion_sb.pending_fusions.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result sink. A requested hold-off takes priority and is counted here, so the
  // sender keeps pushing while the output register and the core both fill up.
  // Otherwise stall bursts are mostly short with the odd long one.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_served != hold_requested) begin
      hold_served = hold_requested;
      stall_left  = HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (drain_stalls_on && $urandom_range(0, 3) == 0) begin
      stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80)
                                                : $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Result monitor: sampled at the edge, so values are the pre-edge ones
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      fusion_sb.check_fused_output(fused_range_o, kalman_gain_o);
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One register write transaction; valid is dropped for a cycle afterwards
  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [DataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    fusion_sb.write_register(index, data);
    reg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // One ranging event. Valid stays high into the next call when gap is zero,
  // so back-to-back transactions never see valid dropped and re-raised.
  task automatic send_event(input logic signed [DataW-1:0] range_in,
                            input logic signed [RawW-1:0] raw,
                            input int unsigned gap);
    in_valid_i       <= 1'b1;
    range_distance_i <= range_in;
    accel_x_raw_i    <= raw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    fusion_sb.note_ranging_event(range_in, raw);
    items_sent++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Let everything outstanding come back, then allow the core to settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (fusion_sb.pending_fusions.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!feed_gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Extremes, a full random word, or a modest value in the useful range
  function automatic logic [DataW-1:0] pick_word(int unsigned modest_max);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(0, modest_max);
    endcase
  endfunction

  task automatic randomise_settings();
    logic [DataW-1:0] noise;
    logic [DataW-1:0] bias;
    case ($urandom_range(0, 9))
      0:       noise = '0;     // gain of one
      1:       noise = '1;
      2:       noise = $urandom;
      default: noise = $urandom_range(1, 1 << 18);
    endcase
    case ($urandom_range(0, 5))
      0:       bias = 32'h8000_0000;
      1:       bias = 32'h7FFF_FFFF;
      2:       bias = $urandom;
      default: bias = DataW'($urandom_range(0, 1 << 21)) - DataW'(1 << 20);
    endcase
    write_reg(CfgProcessNoise, pick_word(1 << 18));
    write_reg(CfgMeasurementNoise, noise);
    write_reg(CfgAccelScale, pick_word(1 << 26));
    write_reg(CfgAccelBias, bias);
    write_reg(CfgImuWeight, pick_word(1 << 26));
    if ($urandom_range(0, 2) == 0)
      write_reg(CfgIdxW'($urandom_range(CfgImuWeight + 1, CfgIdxLast)), $urandom);
    settings_used++;
  endtask

  // Mostly distances near the current estimate, as a real range stream would be,
  // with full-range words and the extremes mixed in
  task automatic send_random_event(input int unsigned gap);
    logic signed [DataW-1:0] range_in;
    logic signed [RawW-1:0]  raw;
    logic [DataW-1:0]        offset;
    offset = DataW'($urandom_range(0, 1 << 21)) - DataW'(1 << 20);
    case ($urandom_range(0, 15))
      0:          range_in = 32'sh8000_0000;
      1:          range_in = 32'sh7FFF_FFFF;
      2, 3, 4, 5: range_in = $urandom;
      default:    range_in = fusion_sb.estimate + offset;
    endcase
    case ($urandom_range(0, 9))
      0:       raw = 16'sh8000;
      1:       raw = 16'sh7FFF;
      default: raw = RawW'($urandom);
    endcase
    send_event(range_in, raw, gap);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase;
    int unsigned count;

    fusion_sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: field extremes and a couple of plain readings
    send_event(32'sd0, 16'sd0, pick_gap());
    send_event(32'sh7FFF_FFFF, 16'sh7FFF, pick_gap());
    send_event(32'sh8000_0000, 16'sh8000, pick_gap());
    send_event(32'sd327680, 16'sd1000, pick_gap());
    send_event(-32'sd65536, -16'sd1, pick_gap());
    wait_drained();

    // Covariance overflow with zero measurement noise: gain of one, and the
    // largest calibration path drives the estimate into positive saturation
    write_reg(CfgProcessNoise, '1);
    write_reg(CfgMeasurementNoise, '0);
    write_reg(CfgAccelScale, '1);
    write_reg(CfgAccelBias, 32'h8000_0000);
    write_reg(CfgImuWeight, '1);
    settings_used++;
    send_event(32'sh7FFF_FFFF, 16'sh7FFF, pick_gap());
    send_event(32'sh8000_0000, 16'sh8000, pick_gap());
    wait_drained();

    // Unmapped indexes must leave every register alone
    write_reg(CfgIdxW'(CfgImuWeight + 1), '0);
    write_reg(CfgIdxLast, 32'h5A5A_A5A5);
    send_event(32'sd0, 16'sd0, pick_gap());
    wait_drained();

    // Largest bias: negative saturation
    write_reg(CfgAccelBias, 32'h7FFF_FFFF);
    send_event(32'sh8000_0000, 16'sh8000, pick_gap());
    send_event(32'sh7FFF_FFFF, 16'sh0100, pick_gap());
    wait_drained();

    // Covariance is now zero; with no process noise the gain denominator
    // vanishes and the estimate must hold
    write_reg(CfgProcessNoise, '0);
    send_event(32'sd12345, 16'sd5, pick_gap());
    send_event(32'sh7FFF_FFFF, 16'sh8000, pick_gap());
    wait_drained();

    write_reg(CfgMeasurementNoise, 32'd1);
    send_event(-32'sd1000, 16'sd7, pick_gap());
    wait_drained();

    // Smallest nonzero prior: the covariance update rounds on an exact half
    write_reg(CfgProcessNoise, 32'd1);
    send_event(32'sd65536, 16'sd0, pick_gap());
    send_event(-32'sd65536, 16'sd0, pick_gap());
    wait_drained();

    // Back to the power-up tuning, readings around three metres
    write_reg(CfgProcessNoise, RstProcessNoise);
    write_reg(CfgMeasurementNoise, RstMeasurementNoise);
    write_reg(CfgAccelScale, RstAccelScale);
    write_reg(CfgAccelBias, RstAccelBias);
    write_reg(CfgImuWeight, RstImuWeight);
    settings_used++;
    repeat (5)
      send_event(32'sd196608 + DataW'($urandom_range(0, 1 << 14)),
                 RawW'($urandom_range(0, 1 << 12)), pick_gap());
    directed_sent = items_sent;

    // Random phases, each with fresh settings. Phases numbered 1 mod 4 run without
    // feed gaps (phase 1 also takes the long output hold-off), phases numbered 2 mod 4
    // without sink stalls; phase 3 pauses midway until every result has come back.
    phase = 0;
    while (random_sent < RandomItems) begin
      wait_drained();
      randomise_settings();
      feed_gaps_on    = (phase % 4 != 1);
      drain_stalls_on = (phase % 4 != 2);
      count = $urandom_range(80, 170);
      for (int unsigned i = 0; i < count; i++) begin
        if (phase == 1 && i == 20) hold_requested++;
        if (phase == 3 && i == count / 2) wait_drained();
        send_random_event(pick_gap());
        random_sent++;
      end
      phase++;
    end

    wait_drained();

    $display("Summary: %0d ranging events (%0d directed), %0d results checked, %0d mismatches",
             items_sent, directed_sent, fusion_sb.checked, fusion_sb.mismatches);
    $display("Covered %0d settings over %0d register writes, incl. unity and zero gain, %s",
             settings_used, reg_writes, "saturation and a long output hold-off");
    if (fusion_sb.pending_fusions.size() != 0)
      $display("%0d expected results never arrived", fusion_sb.pending_fusions.size());

    if (fusion_sb.mismatches == 0 && fusion_sb.pending_fusions.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* scalar_kalman_range_fusion.f */
rtl/core/skrf_pkg.sv
rtl/core/skrf_mul.sv
rtl/core/skrf_div.sv
rtl/core/scalar_kalman_range_fusion.sv
dv/tb_top.sv
